@@ hw/rtl/hpg_pkg.sv @@
// hpg_pkg: shared types and constants of the heartbeat pulse generator
// used by every module of the block, no dependencies
package hpg_pkg;

  localparam int TS_W     = 64;
  localparam int PERIOD_W = 20;
  localparam int LEVEL_IN_W = 16;
  localparam int LEVEL_W  = 24;
  localparam int SEG_W    = 3;
  localparam int U_W      = 16;
  localparam int NUM_W    = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [SEG_W-1:0] SEG_RISE1 = 3'd0;
  localparam logic [SEG_W-1:0] SEG_FALL1 = 3'd1;
  localparam logic [SEG_W-1:0] SEG_RISE2 = 3'd2;
  localparam logic [SEG_W-1:0] SEG_FALL2 = 3'd3;
  localparam logic [SEG_W-1:0] SEG_REST  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REST   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BEAT   = 2'd2;

  localparam logic [PERIOD_W-1:0]   PERIOD_RESET = 20'd1000;
  localparam logic [LEVEL_IN_W-1:0] REST_RESET   = 16'd0;
  localparam logic [LEVEL_IN_W-1:0] BEAT_RESET   = 16'd255;

  // phase after the modulo pipeline
  typedef struct packed {
    logic                valid;
    logic                rest;
    logic [PERIOD_W-1:0] t;
  } mod_out_t;

  // segment and position inside it
  typedef struct packed {
    logic             valid;
    logic [SEG_W-1:0] seg;
    logic [U_W-1:0]   u;
  } frac_out_t;

endpackage

@@ hw/rtl/hpg_mod.sv @@
// hpg_mod: timestamp modulo period, one restoring step per stage
// depends on hpg_pkg
module hpg_mod (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [hpg_pkg::TS_W-1:0]      ts,
  input  logic [hpg_pkg::PERIOD_W-1:0]  period,
  output hpg_pkg::mod_out_t             out
);

  localparam int NST = hpg_pkg::TS_W - 1;
  localparam int PW  = hpg_pkg::PERIOD_W;

  logic          src_v   [0:NST-1];
  logic          src_rs  [0:NST-1];
  logic [PW-1:0] src_rem [0:NST-1];
  logic [NST-1:0] src_dvd [0:NST-1];

  logic          st_v   [1:NST];
  logic          st_rs  [1:NST];
  logic [PW-1:0] st_rem [1:NST];
  logic [NST-1:0] st_dvd [1:NST];

  genvar k;
  generate
    for (k = 0; k < NST; k++) begin : g_step
      logic [PW:0] r2;
      logic [PW:0] r2_sub;
      logic        ge;
      if (k == 0) begin : g_first
        assign src_v[k]   = in_valid;
        assign src_rs[k]  = ts[hpg_pkg::TS_W-1] | (period == '0);
        assign src_rem[k] = '0;
        assign src_dvd[k] = ts[NST-1:0];
      end else begin : g_rest
        assign src_v[k]   = st_v[k];
        assign src_rs[k]  = st_rs[k];
        assign src_rem[k] = st_rem[k];
        assign src_dvd[k] = st_dvd[k];
      end
      assign r2     = {src_rem[k], src_dvd[k][NST-1]};
      assign ge     = r2 >= {1'b0, period};
      assign r2_sub = r2 - {1'b0, period};
      always_ff @(posedge clk) begin
        if (rst) begin
          st_v[k+1] <= 1'b0;
        end else if (en) begin
          st_v[k+1] <= src_v[k];
        end
        if (en) begin
          st_rs[k+1]  <= src_rs[k];
          st_rem[k+1] <= ge ? r2_sub[PW-1:0] : r2[PW-1:0];
          st_dvd[k+1] <= {src_dvd[k][NST-2:0], 1'b0};
        end
      end
    end
  endgenerate

  assign out.valid = st_v[NST];
  assign out.rest  = st_rs[NST];
  assign out.t     = st_rem[NST];

endmodule

@@ hw/rtl/hpg_frac.sv @@
// hpg_frac: segment select and q0.16 position by a pipelined restoring divide
// depends on hpg_pkg
module hpg_frac (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  hpg_pkg::mod_out_t             in,
  input  logic [hpg_pkg::PERIOD_W-1:0]  period,
  output hpg_pkg::frac_out_t            out
);

  localparam int NW = hpg_pkg::NUM_W;
  localparam int UW = hpg_pkg::U_W;
  localparam int CW = NW + 2;

  logic [CW-1:0] t10, t4, t20, p1, p2, p3, p5, p7, p9, p11;
  logic [hpg_pkg::SEG_W-1:0] seg_c;
  logic [CW-1:0] num_c, den_c;

  always_comb begin
    t10 = CW'(in.t) * CW'(10);
    t4  = CW'(in.t) * CW'(4);
    t20 = CW'(in.t) * CW'(20);
    p1  = CW'(period);
    p2  = p1 * CW'(2);
    p3  = p1 * CW'(3);
    p5  = p1 * CW'(5);
    p7  = p1 * CW'(7);
    p9  = p1 * CW'(9);
    p11 = p1 * CW'(11);
    seg_c = hpg_pkg::SEG_REST;
    num_c = '0;
    den_c = p2;
    if (!in.rest) begin
      if (t10 < p1) begin
        seg_c = hpg_pkg::SEG_RISE1;
        num_c = t20;
        den_c = p2;
      end else if (t4 < p1) begin
        seg_c = hpg_pkg::SEG_FALL1;
        num_c = t20 - p2;
        den_c = p3;
      end else if (t20 < p7) begin
        seg_c = hpg_pkg::SEG_RISE2;
        num_c = t20 - p5;
        den_c = p2;
      end else if (t10 < p9) begin
        seg_c = hpg_pkg::SEG_FALL2;
        num_c = t20 - p7;
        den_c = p11;
      end
    end
  end

  logic                      st_v   [0:UW];
  logic [hpg_pkg::SEG_W-1:0] st_seg [0:UW];
  logic [NW-1:0]             st_r   [0:UW];
  logic [NW-1:0]             st_den [0:UW];
  logic [UW-1:0]             st_q   [0:UW];

  // entry stage: segment decode
  always_ff @(posedge clk) begin
    if (rst) begin
      st_v[0] <= 1'b0;
    end else if (en) begin
      st_v[0] <= in.valid;
    end
    if (en) begin
      st_seg[0] <= seg_c;
      st_r[0]   <= num_c[NW-1:0];
      st_den[0] <= den_c[NW-1:0];
      st_q[0]   <= '0;
    end
  end

  genvar k;
  generate
    for (k = 0; k < UW; k++) begin : g_div
      logic [NW:0] r2;
      logic [NW:0] r2_sub;
      logic        ge;
      assign r2     = {st_r[k], 1'b0};
      assign ge     = r2 >= {1'b0, st_den[k]};
      assign r2_sub = r2 - {1'b0, st_den[k]};
      always_ff @(posedge clk) begin
        if (rst) begin
          st_v[k+1] <= 1'b0;
        end else if (en) begin
          st_v[k+1] <= st_v[k];
        end
        if (en) begin
          st_seg[k+1] <= st_seg[k];
          st_den[k+1] <= st_den[k];
          st_r[k+1]   <= ge ? r2_sub[NW-1:0] : r2[NW-1:0];
          st_q[k+1]   <= {st_q[k][UW-2:0], ge};
        end
      end
    end
  endgenerate

  assign out.valid = st_v[UW];
  assign out.seg   = st_seg[UW];
  assign out.u     = st_q[UW];

endmodule

@@ hw/rtl/hpg_ease.sv @@
// hpg_ease: cubic ease 3u^2-2u^3, scaling by the level swing and rounding
// depends on hpg_pkg
module hpg_ease (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  hpg_pkg::frac_out_t              in,
  input  logic [hpg_pkg::LEVEL_IN_W-1:0]  rest_level,
  input  logic [hpg_pkg::LEVEL_IN_W-1:0]  beat_level,
  output logic                            out_valid,
  output logic [hpg_pkg::LEVEL_W-1:0]     out_level,
  output logic [hpg_pkg::SEG_W-1:0]       out_seg
);

  localparam int SW = hpg_pkg::SEG_W;
  localparam int LW = hpg_pkg::LEVEL_W;

  // e1: u^2
  logic          v1;
  logic [SW-1:0] seg1;
  logic [15:0]   u1;
  logic [31:0]   u2;
  // e2: u^3 and 3u^2 scaled
  logic          v2;
  logic [SW-1:0] seg2;
  logic [47:0]   u3;
  logic [49:0]   a2;
  // e3: ease value and swing
  logic          v3;
  logic [SW-1:0] seg3;
  logic [47:0]   h3;
  logic [15:0]   mag3;
  logic          neg3;
  logic [15:0]   from3;
  // e4: partial products
  logic          v4;
  logic [SW-1:0] seg4;
  logic [47:0]   plo4;
  logic [31:0]   phi4;
  logic          neg4;
  logic [15:0]   from4;
  // e5: rounded magnitude
  logic          v5;
  logic [SW-1:0] seg5;
  logic [LW-1:0] r5;
  logic          neg5;
  logic [15:0]   from5;

  logic        fall_c;
  logic [15:0] from_c, to_c;
  logic [16:0] diff_c, absd_c;
  logic [63:0] sum_c;
  logic [LW-1:0] d_c, lvl_c;

  always_comb begin
    fall_c = (seg2 == hpg_pkg::SEG_FALL1) || (seg2 == hpg_pkg::SEG_FALL2);
    from_c = fall_c ? beat_level : rest_level;
    to_c   = fall_c ? rest_level : beat_level;
    diff_c = {to_c[15], to_c} - {from_c[15], from_c};
    absd_c = diff_c[16] ? (17'd0 - diff_c) : diff_c;
    sum_c  = {phi4, 32'd0} + {16'd0, plo4} + (64'd1 << 39);
    d_c    = neg5 ? (LW'(0) - r5) : r5;
    if (seg5 == hpg_pkg::SEG_REST) begin
      lvl_c = {rest_level, 8'd0};
    end else begin
      lvl_c = {from5, 8'd0} + d_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      out_valid <= v5;
    end
    if (en) begin
      seg1  <= in.seg;
      u1    <= in.u;
      u2    <= in.u * in.u;
      seg2  <= seg1;
      u3    <= u2 * u1;
      a2    <= {18'd0, u2} * 50'd196608;
      seg3  <= seg2;
      h3    <= 48'(a2 - {1'b0, u3, 1'b0});
      mag3  <= absd_c[15:0];
      neg3  <= diff_c[16];
      from3 <= from_c;
      seg4  <= seg3;
      plo4  <= mag3 * h3[31:0];
      phi4  <= mag3 * h3[47:32];
      neg4  <= neg3;
      from4 <= from3;
      seg5  <= seg4;
      r5    <= sum_c[63:40];
      neg5  <= neg4;
      from5 <= from4;
      out_seg   <= seg5;
      out_level <= lvl_c;
    end
  end

endmodule

@@ hw/rtl/heartbeat_pulse_generator_core.sv @@
// heartbeat pulse generator: each input item becomes one result item
// throughput one item per cycle: 63 modulo steps, 1 segment decode, 16 divide
// steps and 6 ease/multiply stages, all advancing together on one stall enable
// synchronous active-high reset clears valid bits and loads the register defaults
// (period 1000, rest 0, beat 255); no clearing pass, ready right after reset
// depends on hpg_pkg, hpg_mod, hpg_frac, hpg_ease
module heartbeat_pulse_generator_core (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] timestamp
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [23:0] level, [26:24] segment, rest zero
  // register writes
  input  logic                           cfg_we,
  input  logic [hpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hpg_pkg::PERIOD_W-1:0]   cfg_data
);

  logic [hpg_pkg::PERIOD_W-1:0]   period_ticks;
  logic [hpg_pkg::LEVEL_IN_W-1:0] rest_level;
  logic [hpg_pkg::LEVEL_IN_W-1:0] beat_level;

  // register file; unknown indices are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      period_ticks <= hpg_pkg::PERIOD_RESET;
      rest_level   <= hpg_pkg::REST_RESET;
      beat_level   <= hpg_pkg::BEAT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        hpg_pkg::REG_PERIOD: period_ticks <= cfg_data;
        hpg_pkg::REG_REST:   rest_level   <= cfg_data[hpg_pkg::LEVEL_IN_W-1:0];
        hpg_pkg::REG_BEAT:   beat_level   <= cfg_data[hpg_pkg::LEVEL_IN_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless a finished item is held at the output
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  hpg_pkg::mod_out_t  phase;
  hpg_pkg::frac_out_t frac;
  logic [hpg_pkg::LEVEL_W-1:0] level;
  logic [hpg_pkg::SEG_W-1:0]   segment;

  // phase = timestamp mod period, flags negative time and zero period
  hpg_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .ts       (s_tdata),
    .period   (period_ticks),
    .out      (phase)
  );

  // segment and position inside the segment
  hpg_frac u_frac (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in     (phase),
    .period (period_ticks),
    .out    (frac)
  );

  // ease curve, swing scaling and rounding; last stage is the output register
  hpg_ease u_ease (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in         (frac),
    .rest_level (rest_level),
    .beat_level (beat_level),
    .out_valid  (m_tvalid),
    .out_level  (level),
    .out_seg    (segment)
  );

  assign m_tdata = {5'd0, segment, level};

  // segment code never beyond rest
  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (segment <= hpg_pkg::SEG_REST))
    else $error("segment code out of range");

  // rest items carry the rest level exactly
  a_rest_level: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && segment == hpg_pkg::SEG_REST) |-> (level == {rest_level, 8'd0}))
    else $error("rest item with wrong level");

  // a held result stays put while the pipeline is stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("held result changed during stall");

endmodule

@@ bench/tb_top.sv @@
// testbench of the heartbeat pulse generator: random and directed timestamps
// against a behavioural model of the level curve; depends on hpg_pkg and the core
`timescale 1ns / 1ps

module tb_top;

  localparam int LATENCY = 86;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [hpg_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // [63:0] timestamp
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [23:0] level, [26:24] segment, rest zero
  logic                          cfg_we;
  logic [hpg_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [hpg_pkg::PERIOD_W-1:0]  cfg_data;

  heartbeat_pulse_generator_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic [hpg_pkg::SEG_W-1:0]   seg;
    logic [hpg_pkg::LEVEL_W-1:0] level;
  } beat_result_t;

  // model copy of the registers
  logic [hpg_pkg::PERIOD_W-1:0] period_q;
  logic signed [15:0]    rest_q;
  logic signed [15:0]    beat_q;

  logic [63:0]   timestamp_queue[$];
  beat_result_t  expected_levels[$];

  int  mismatches;
  int  watchdog;
  bit  no_idle;       // last part of the run, no gaps on either side
  bit  in_taken;      // item on the input was accepted at the last edge
  int  send_gap;
  int  recv_gap;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cubic ease between two levels, u taken as num/den in Q0.16
  function automatic logic signed [31:0] ease_level(logic signed [15:0] from_lvl,
      logic signed [15:0] to_lvl, logic [63:0] num, logic [63:0] den);
    logic [63:0] u;
    logic [63:0] h;
    logic [63:0] mag;
    logic [63:0] r;
    logic signed [31:0] diff;
    u = (num << 16) / den;
    h = 64'd3 * u * u * 64'd65536 - 64'd2 * u * u * u;
    diff = 32'(from_lvl) - 32'(to_lvl);
    diff = -diff;
    mag = diff < 0 ? 64'(-diff) : 64'(diff);
    r = (mag * h + (64'd1 << 39)) >> 40;
    return 32'(from_lvl) * 256 + (diff < 0 ? -32'(r) : 32'(r));
  endfunction

  function automatic beat_result_t heartbeat_at(logic [63:0] ts);
    beat_result_t res;
    logic [63:0] p;
    logic [63:0] t;
    logic signed [31:0] lvl;
    p = 64'(period_q);
    lvl = 32'(rest_q) * 256;
    res.seg = hpg_pkg::SEG_REST;
    if (p != 0 && !ts[63]) begin
      t = ts % p;
      if (10 * t < p) begin
        res.seg = hpg_pkg::SEG_RISE1;
        lvl = ease_level(rest_q, beat_q, 20 * t, 2 * p);
      end else if (4 * t < p) begin
        res.seg = hpg_pkg::SEG_FALL1;
        lvl = ease_level(beat_q, rest_q, 20 * t - 2 * p, 3 * p);
      end else if (20 * t < 7 * p) begin
        res.seg = hpg_pkg::SEG_RISE2;
        lvl = ease_level(rest_q, beat_q, 20 * t - 5 * p, 2 * p);
      end else if (10 * t < 9 * p) begin
        res.seg = hpg_pkg::SEG_FALL2;
        lvl = ease_level(beat_q, rest_q, 20 * t - 7 * p, 11 * p);
      end
    end
    res.level = lvl[hpg_pkg::LEVEL_W-1:0];
    return res;
  endfunction

  // driver: gaps in bursts, predicts at acceptance
  always @(posedge clk) begin
    if (rst) begin
      send_gap <= 0;
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        expected_levels.push_back(heartbeat_at(s_tdata));
        void'(timestamp_queue.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && !in_taken) begin
        // item still waiting, valid and data held
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 15) == 0) begin
        send_gap <= $urandom_range(1, 14);
        s_tvalid <= 1'b0;
      end else if (timestamp_queue.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= timestamp_queue[0];
      end else begin
        s_tvalid <= 1'b0;
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 15) == 0) begin
        recv_gap <= $urandom_range(1, 14);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // monitor: compare each result item with the oldest expectation
  always @(posedge clk) begin
    beat_result_t want;
    if (rst) begin
      watchdog <= 0;
    end else begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (m_tvalid && m_tready) begin
        if (expected_levels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %h", m_tdata);
        end else begin
          want = expected_levels.pop_front();
          if (m_tdata[23:0] != want.level || m_tdata[26:24] != want.seg) begin
            mismatches++;
            if (mismatches <= 10)
              $display("level exp %h seg %0d, got level %h seg %0d", want.level,
                       want.seg, m_tdata[23:0], m_tdata[26:24]);
          end
        end
      end
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [hpg_pkg::CFG_IDX_W-1:0] idx,
      logic [hpg_pkg::PERIOD_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      hpg_pkg::REG_PERIOD: period_q = val;
      hpg_pkg::REG_REST:   rest_q = val[15:0];
      hpg_pkg::REG_BEAT:   beat_q = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    while (timestamp_queue.size() > 0 || expected_levels.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // random timestamp: mostly small phases, sometimes full width
  function automatic logic [63:0] random_stamp();
    logic [63:0] ts;
    case ($urandom_range(0, 5))
      0: ts = {$urandom, $urandom};
      1: ts = {1'b0, 31'($urandom), $urandom};
      default: ts = 64'($urandom_range(0, 3 * (period_q + 1)));
    endcase
    return ts;
  endfunction

  task automatic run_phase(int count);
    for (int i = 0; i < count; i++) timestamp_queue.push_back(random_stamp());
    drain();
  endtask

  initial begin
    logic [63:0] p;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    no_idle = 1'b0;
    send_gap = 0;
    recv_gap = 0;
    period_q = hpg_pkg::PERIOD_RESET;
    rest_q = hpg_pkg::REST_RESET;
    beat_q = hpg_pkg::BEAT_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: segment borders at reset period, negative and extreme stamps
    p = 64'(period_q);
    timestamp_queue.push_back(64'd0);
    timestamp_queue.push_back(p / 10 - 1);
    timestamp_queue.push_back(p / 10);
    timestamp_queue.push_back(p / 4 - 1);
    timestamp_queue.push_back(p / 4);
    timestamp_queue.push_back(p * 7 / 20 - 1);
    timestamp_queue.push_back(p * 7 / 20);
    timestamp_queue.push_back(p * 9 / 10 - 1);
    timestamp_queue.push_back(p * 9 / 10);
    timestamp_queue.push_back(p - 1);
    timestamp_queue.push_back(p);
    timestamp_queue.push_back(64'h7FFF_FFFF_FFFF_FFFF);
    timestamp_queue.push_back(64'h8000_0000_0000_0000);
    timestamp_queue.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    timestamp_queue.push_back(64'h5555_5555_5555_5555);
    timestamp_queue.push_back(64'h2AAA_AAAA_AAAA_AAAA);
    drain();

    // extremes of the levels, largest period
    write_reg(hpg_pkg::REG_REST, 20'h08000);
    write_reg(hpg_pkg::REG_BEAT, 20'h07FFF);
    write_reg(hpg_pkg::REG_PERIOD, 20'hFFFFF);
    run_phase(60);
    write_reg(hpg_pkg::REG_REST, 20'h07FFF);
    write_reg(hpg_pkg::REG_BEAT, 20'h08000);
    write_reg(hpg_pkg::REG_PERIOD, 20'd1);
    run_phase(20);
    // period zero disables
    write_reg(hpg_pkg::REG_PERIOD, 20'd0);
    run_phase(20);
    // unused register index is ignored
    write_reg(REG_UNUSED, 20'hFFFFF);
    write_reg(hpg_pkg::REG_PERIOD, 20'd20);
    run_phase(40);
    for (int k = 0; k < 8; k++) begin
      write_reg(hpg_pkg::REG_PERIOD, 20'($urandom_range(1, k < 6 ? 5000 : 1048575)));
      write_reg(hpg_pkg::REG_REST, 20'($urandom));
      write_reg(hpg_pkg::REG_BEAT, 20'($urandom));
      if (k == 7) no_idle = 1'b1;
      run_phase(50);
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
